### sv/b32dl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b32dl_pkg
// Shared types, constants and helpers of the base32 DNS label encoder.
// ----------------------------------------------------------------------------
package b32dl_pkg;

  localparam int MAX_LABEL_CHARS = 63;
  localparam int MAX_LABELS      = 127;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 6;
  localparam int LIM_W      = 7;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CODE_W     = 5;
  localparam int CHAR_W     = 7;
  localparam int STORE_W    = 4;
  localparam int BCNT_W     = 3;
  localparam int WIN_W      = STORE_W + BYTE_W;
  localparam int MAX_CODES  = 3;
  localparam int NCODE_W    = 2;
  localparam int MAX_RES    = 6;
  localparam int RES_CNT_W  = 3;
  localparam int Q_DEPTH    = 2;

  localparam logic [CHAR_W-1:0] DOT_CHAR   = 7'h2E;
  localparam logic [CHAR_W-1:0] ALPHA_BASE = 7'h61;
  localparam logic [CHAR_W-1:0] DIGIT_BASE = 7'h32;
  localparam logic [CODE_W-1:0] NUM_ALPHA  = 5'd26;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LABEL_LENGTH = 1'b0,
    REG_LABEL_LIMIT  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [LEN_W-1:0] label_length;
    logic [LIM_W-1:0] label_limit;
  } cfg_t;

  typedef struct packed {
    logic [MAX_CODES-1:0][CODE_W-1:0] code;
    logic [NCODE_W-1:0]               ncode;
    logic                             last;
  } job_t;

  typedef struct packed {
    logic full;
    logic avail;
  } q_stat_t;

  function automatic logic [CHAR_W-1:0] b32_char(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    if (code < NUM_ALPHA) begin
      ch = ALPHA_BASE + CHAR_W'(code);
    end else begin
      ch = DIGIT_BASE + CHAR_W'(code - NUM_ALPHA);
    end
    return ch;
  endfunction

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = (len == '0) ? LEN_W'(1) : len;
    if (int'(n) > MAX_LABEL_CHARS) begin
      n = LEN_W'(MAX_LABEL_CHARS);
    end
    return n;
  endfunction

  function automatic logic [LIM_W-1:0] eff_limit(input logic [LIM_W-1:0] lim);
    logic [LIM_W-1:0] n;
    n = lim;
    if (int'(n) > MAX_LABELS) begin
      n = LIM_W'(MAX_LABELS);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

### sv/b32dl_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b32dl_in_if / b32dl_out_if
// Valid/ready channels for message bytes and encoded characters.
// ----------------------------------------------------------------------------
interface b32dl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b32dl_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       char_valid;
  logic       truncated;
  logic       end_of_message;

  modport source (output valid, output out_char, output char_valid, output truncated,
                  output end_of_message, input ready);
  modport sink   (input valid, input out_char, input char_valid, input truncated,
                  input end_of_message, output ready);
endinterface
`default_nettype wire

### sv/base32_dns_label_encoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// base32_dns_label_encoder_unit
// Lowercase base32 encoder (no padding) that cuts output into DNS labels.
// ----------------------------------------------------------------------------
// Accepts one message byte per beat and returns lowercase base32 characters,
// MSB first, with '.' between labels of label_length characters; characters
// past label_limit labels are dropped and flagged as truncated. The output
// side delivers one character or separator per cycle while the sink is
// ready; a byte yields usually one or two results, up to six on a final byte
// that crosses label boundaries. The intake side slices bytes ahead through
// a two-entry job queue, so bytes are taken while earlier characters still
// wait. With the output side idle, an accepted byte is first written into the
// job queue and then loaded into the output buffer, from which its first
// result is offered.
// ----------------------------------------------------------------------------
module base32_dns_label_encoder_unit import b32dl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  b32dl_in_if.sink              in_ch,
  b32dl_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg_r, cfg_nxt;
  q_stat_t q_stat;
  logic    push;
  logic    pop;
  job_t    push_job;
  job_t    head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LABEL_LENGTH: cfg_nxt.label_length = cfg_data[LEN_W-1:0];
        REG_LABEL_LIMIT:  cfg_nxt.label_limit  = cfg_data[LIM_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.label_length <= LEN_W'(63);
      cfg_r.label_limit  <= LIM_W'(4);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  b32dl_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (push),
    .job    (push_job)
  );

  b32dl_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_stat   (q_stat),
    .head     (head)
  );

  b32dl_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

### sv/b32dl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b32dl_front
// Byte intake: slices the bit window into 5-bit codes and queues them.
// ----------------------------------------------------------------------------
module b32dl_front import b32dl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  b32dl_in_if.sink    in_ch,
  input  q_stat_t     q_stat,
  output logic        push,
  output job_t        job
);

  logic [STORE_W-1:0] store_r, store_nxt;
  logic [BCNT_W-1:0]  bcnt_r, bcnt_nxt;

  logic [WIN_W-1:0]   win;
  logic [WIN_W-1:0]   left;
  logic [3:0]         total;
  logic [3:0]         rem;
  logic [CODE_W-1:0]  tail;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  always_comb begin
    win   = {store_r, in_ch.data_byte};
    total = 4'(bcnt_r) + 4'd8;
    job   = '0;
    job.last    = in_ch.last_byte;
    job.code[0] = CODE_W'(win >> (total - 4'd5));
    if (total >= 4'd10) begin
      job.code[1] = CODE_W'(win >> (total - 4'd10));
      rem         = total - 4'd10;
      job.ncode   = NCODE_W'(2);
    end else begin
      rem         = total - 4'd5;
      job.ncode   = NCODE_W'(1);
    end
    left = win & ((WIN_W'(1) << rem) - WIN_W'(1));
    tail = CODE_W'(left << (4'd5 - rem));
    if (in_ch.last_byte && rem != 4'd0) begin
      job.code[job.ncode] = tail;
      job.ncode           = job.ncode + NCODE_W'(1);
    end
    store_nxt = store_r;
    bcnt_nxt  = bcnt_r;
    if (push) begin
      store_nxt = in_ch.last_byte ? '0 : STORE_W'(left);
      bcnt_nxt  = in_ch.last_byte ? '0 : BCNT_W'(rem);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      bcnt_r  <= '0;
    end else begin
      store_r <= store_nxt;
      bcnt_r  <= bcnt_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/b32dl_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b32dl_fifo
// Short register queue of code jobs between intake and character output.
// ----------------------------------------------------------------------------
module b32dl_fifo import b32dl_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output q_stat_t q_stat,
  output job_t    head
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  job_t             mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == CNT_W'(Q_DEPTH));
  assign q_stat.avail = (cnt_r != '0);
  assign head         = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/b32dl_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b32dl_back
// Label builder: expands one code job into characters and separators,
// then shifts them out one beat per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module b32dl_back import b32dl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  q_stat_t     q_stat,
  input  job_t        head,
  output logic        pop,
  b32dl_out_if.source out_ch
);

  logic [CHAR_W-1:0]    buf_r [MAX_RES];
  logic [CHAR_W-1:0]    buf_nxt [MAX_RES];
  logic [RES_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 cv_r, cv_nxt;
  logic                 last_r, last_nxt;
  logic                 trunc_r, trunc_nxt;
  logic [LEN_W-1:0]     cil_r, cil_nxt;
  logic [LIM_W-1:0]     lab_r, lab_nxt;
  logic                 drop_r, drop_nxt;

  logic                 take;
  logic [LEN_W-1:0]     e_len;
  logic [LIM_W-1:0]     e_lim;
  logic [CHAR_W-1:0]    res [MAX_RES];
  logic [RES_CNT_W-1:0] n;
  logic [LEN_W-1:0]     c;
  logic [LIM_W-1:0]     l;
  logic                 d;
  logic                 ok;
  logic                 cv;

  assign take                  = out_ch.valid && out_ch.ready;
  assign pop                   = q_stat.avail && (cnt_r == '0 ||
                                 (take && cnt_r == RES_CNT_W'(1)));
  assign out_ch.valid          = (cnt_r != '0);
  assign out_ch.out_char       = buf_r[0];
  assign out_ch.char_valid     = cv_r;
  assign out_ch.truncated      = trunc_r;
  assign out_ch.end_of_message = last_r && (cnt_r == RES_CNT_W'(1));

  assign e_len = eff_len(cfg.label_length);
  assign e_lim = eff_limit(cfg.label_limit);

  // expand up to three codes against the running label state
  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '0;
    end
    n  = '0;
    c  = cil_r;
    l  = lab_r;
    d  = drop_r;
    ok = 1'b0;
    cv = 1'b1;
    for (int k = 0; k < MAX_CODES; k++) begin
      if (NCODE_W'(k) < head.ncode) begin
        ok = 1'b1;
        if (l == '0) begin
          if (e_lim == '0) begin
            d  = 1'b1;
            ok = 1'b0;
          end else begin
            l = LIM_W'(1);
            c = '0;
          end
        end else if (c >= e_len) begin
          if (l >= e_lim) begin
            d  = 1'b1;
            ok = 1'b0;
          end else begin
            res[n] = DOT_CHAR;
            n      = n + RES_CNT_W'(1);
            l      = l + LIM_W'(1);
            c      = '0;
          end
        end
        if (ok) begin
          res[n] = b32_char(head.code[k]);
          n      = n + RES_CNT_W'(1);
          c      = c + LEN_W'(1);
        end
      end
    end
    if (head.last && n == '0) begin
      n  = RES_CNT_W'(1);
      cv = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      buf_nxt[i] = buf_r[i];
    end
    cnt_nxt   = cnt_r;
    cv_nxt    = cv_r;
    last_nxt  = last_r;
    trunc_nxt = trunc_r;
    cil_nxt   = cil_r;
    lab_nxt   = lab_r;
    drop_nxt  = drop_r;
    if (pop) begin
      for (int i = 0; i < MAX_RES; i++) begin
        buf_nxt[i] = res[i];
      end
      cnt_nxt   = n;
      cv_nxt    = cv;
      last_nxt  = head.last;
      trunc_nxt = d;
      cil_nxt   = head.last ? '0 : c;
      lab_nxt   = head.last ? '0 : l;
      drop_nxt  = head.last ? 1'b0 : d;
    end else if (take) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      buf_nxt[MAX_RES-1] = '0;
      cnt_nxt = cnt_r - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      buf_r[i] <= buf_nxt[i];
    end
    if (!rst_n) begin
      cnt_r   <= '0;
      cv_r    <= 1'b0;
      last_r  <= 1'b0;
      trunc_r <= 1'b0;
      cil_r   <= '0;
      lab_r   <= '0;
      drop_r  <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      cv_r    <= cv_nxt;
      last_r  <= last_nxt;
      trunc_r <= trunc_nxt;
      cil_r   <= cil_nxt;
      lab_r   <= lab_nxt;
      drop_r  <= drop_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RES_CNT_W'(MAX_RES))
    else $error("result count exceeds buffer depth");

  a_empty_close: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0 && !cv_r) |-> (cnt_r == RES_CNT_W'(1) && last_r))
    else $error("empty result outside message close");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0 && !out_ch.ready) |=> ($stable(cnt_r) && $stable(last_r)))
    else $error("pending results changed while stalled");

endmodule
`default_nettype wire
